// ----- hw/rtl/cfr_pkg.sv -----
// Shared types, constants and saturating helpers for the conductor Fresnel reflectance block.
package cfr_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int FXW           = 63;
    localparam int MAG_W         = 62;
    localparam int RECUR_STEPS   = 4;
    localparam int CTX_FIELDS    = 13;

    typedef logic signed [FXW-1:0] t_fx;

    localparam logic [MAG_W-1:0]      MAG_MAX = 62'h2000_0000_0000_0000;
    localparam t_fx                   FX_MAX  = 63'sh2000_0000_0000_0000;
    localparam logic signed [FXW:0]   SUM_MAX = 64'sh2000_0000_0000_0000;
    localparam logic signed [FXW:0]   SUM_MIN = -64'sh2000_0000_0000_0000;

    function automatic t_fx fx_sat(input logic signed [FXW:0] v);
        t_fx res;
        if (v > SUM_MAX) begin
            res = FX_MAX;
        end else if (v < SUM_MIN) begin
            res = -FX_MAX;
        end else begin
            res = v[FXW-1:0];
        end
        return res;
    endfunction

    function automatic t_fx fx_add(input t_fx a, input t_fx b);
        logic signed [FXW:0] s;
        s = {a[FXW-1], a} + {b[FXW-1], b};
        return fx_sat(s);
    endfunction

    function automatic t_fx fx_sub(input t_fx a, input t_fx b);
        logic signed [FXW:0] s;
        s = {a[FXW-1], a} - {b[FXW-1], b};
        return fx_sat(s);
    endfunction

    function automatic logic [MAG_W-1:0] fx_mag(input t_fx v);
        t_fx n;
        n = v[FXW-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/cfr_if.sv -----
// Valid/ready channel interfaces for the input samples and the reflectance results.
interface cfr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] incident_index;
    logic [15:0] metal_index_real;
    logic [15:0] metal_extinction;
    logic [15:0] cos_incidence;

    modport source(output valid, output incident_index, output metal_index_real,
                   output metal_extinction, output cos_incidence, input ready);
    modport sink(input valid, input incident_index, input metal_index_real,
                 input metal_extinction, input cos_incidence, output ready);
endinterface

interface cfr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] reflectance;

    modport source(output valid, output reflectance, input ready);
    modport sink(input valid, input reflectance, output ready);
endinterface

// ----- hw/rtl/cfr_mul.sv -----
// Pipelined multi-lane saturating fixed-point multiplier with a travelling context word.
module cfr_mul #(
    parameter int LANES     = 1,
    parameter int FRAC_BITS = cfr_pkg::FRAC_BITS_DEF,
    parameter int TW        = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cfr_pkg::t_fx  i_a [LANES],
    input  cfr_pkg::t_fx  i_b [LANES],
    input  logic [TW-1:0] i_ctx,
    output logic          o_valid,
    output cfr_pkg::t_fx  o_p [LANES],
    output logic [TW-1:0] o_ctx
);
    localparam int HW = cfr_pkg::MAG_W / 2;
    localparam int PW = 2 * cfr_pkg::MAG_W;

    logic            r_v1, r_v2, r_v3;
    logic [TW-1:0]   r_c1, r_c2, r_c3;
    logic [2*HW-1:0] r_ll [LANES], r_lh [LANES], r_hl [LANES], r_hh [LANES];
    logic            r_n1 [LANES], r_n2 [LANES];
    logic [2*HW:0]   r_mid [LANES];
    logic [2*HW-1:0] r_ll2 [LANES], r_hh2 [LANES];
    cfr_pkg::t_fx    r_p [LANES];
    cfr_pkg::t_fx    n_p [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [PW-1:0]             full;
            logic [PW-1:0]             m;
            logic [cfr_pkg::MAG_W-1:0] mag;
            full = {r_hh2[l], {(2*HW){1'b0}}} + (PW'(r_mid[l]) << HW) + PW'(r_ll2[l]);
            m    = full >> FRAC_BITS;
            if (m > PW'(cfr_pkg::MAG_MAX)) begin
                mag = cfr_pkg::MAG_MAX;
            end else begin
                mag = m[cfr_pkg::MAG_W-1:0];
            end
            n_p[l] = r_n2[l] ? -cfr_pkg::t_fx'({1'b0, mag}) : cfr_pkg::t_fx'({1'b0, mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= i_ctx;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            for (int l = 0; l < LANES; l++) begin
                logic [cfr_pkg::MAG_W-1:0] ua, ub;
                ua = cfr_pkg::fx_mag(i_a[l]);
                ub = cfr_pkg::fx_mag(i_b[l]);
                r_ll[l]  <= ua[HW-1:0] * ub[HW-1:0];
                r_lh[l]  <= ua[HW-1:0] * ub[2*HW-1:HW];
                r_hl[l]  <= ua[2*HW-1:HW] * ub[HW-1:0];
                r_hh[l]  <= ua[2*HW-1:HW] * ub[2*HW-1:HW];
                r_n1[l]  <= i_a[l][cfr_pkg::FXW-1] ^ i_b[l][cfr_pkg::FXW-1];
                r_mid[l] <= {1'b0, r_lh[l]} + {1'b0, r_hl[l]};
                r_ll2[l] <= r_ll[l];
                r_hh2[l] <= r_hh[l];
                r_n2[l]  <= r_n1[l];
                r_p[l]   <= n_p[l];
            end
        end
    end

    assign o_valid = r_v3;
    assign o_ctx   = r_c3;
    assign o_p     = r_p;
endmodule

// ----- hw/rtl/cfr_recur.sv -----
// Pipelined multi-lane restoring divider or integer square root, a few bits per stage.
module cfr_recur #(
    parameter bit SQRT      = 1'b0,
    parameter int LANES     = 1,
    parameter int FRAC_BITS = cfr_pkg::FRAC_BITS_DEF,
    parameter int TW        = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cfr_pkg::t_fx  i_a [LANES],
    input  cfr_pkg::t_fx  i_b [LANES],
    input  logic [TW-1:0] i_ctx,
    output logic          o_valid,
    output cfr_pkg::t_fx  o_p [LANES],
    output logic [TW-1:0] o_ctx
);
    localparam int SPS = cfr_pkg::RECUR_STEPS;
    localparam int MW  = cfr_pkg::MAG_W;
    localparam int NB  = SQRT ? (MW + FRAC_BITS + 1) / 2 : MW + FRAC_BITS;
    localparam int NST = (NB + SPS - 1) / SPS;
    localparam int QW  = NST * SPS;
    localparam int XW  = SQRT ? 2 * QW : QW;
    localparam int RW  = SQRT ? QW + 3 : MW + 1;
    localparam int CW  = (QW > MW ? QW : MW) + 1;

    logic          r_v [NST];
    logic [TW-1:0] r_c [NST];
    logic [XW-1:0] r_x [NST][LANES];
    logic [RW-1:0] r_r [NST][LANES];
    logic [QW-1:0] r_q [NST][LANES];
    logic [MW-1:0] r_d [NST][LANES];
    logic          r_neg [NST][LANES];
    logic          r_z [NST][LANES];

    logic [XW-1:0] n_x [NST][LANES];
    logic [RW-1:0] n_r [NST][LANES];
    logic [QW-1:0] n_q [NST][LANES];
    logic [XW-1:0] s_x [NST][LANES];
    logic [RW-1:0] s_r [NST][LANES];
    logic [QW-1:0] s_q [NST][LANES];
    logic [MW-1:0] s_d [NST][LANES];
    logic          s_neg [NST][LANES];
    logic          s_z [NST][LANES];

    logic          r_ov;
    logic [TW-1:0] r_oc;
    cfr_pkg::t_fx  r_o [LANES];

    // Stage sources: the first stage loads the operands, the rest follow the previous stage.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s_x[0][l]   = XW'(cfr_pkg::fx_mag(i_a[l])) << FRAC_BITS;
            s_r[0][l]   = '0;
            s_q[0][l]   = '0;
            s_d[0][l]   = SQRT ? '0 : cfr_pkg::fx_mag(i_b[l]);
            s_neg[0][l] = SQRT ? 1'b0 : i_a[l][cfr_pkg::FXW-1];
            s_z[0][l]   = SQRT ? (i_a[l][cfr_pkg::FXW-1] || i_a[l] == '0)
                               : (i_b[l][cfr_pkg::FXW-1] || i_b[l] == '0);
            for (int j = 1; j < NST; j++) begin
                s_x[j][l]   = r_x[j-1][l];
                s_r[j][l]   = r_r[j-1][l];
                s_q[j][l]   = r_q[j-1][l];
                s_d[j][l]   = r_d[j-1][l];
                s_neg[j][l] = r_neg[j-1][l];
                s_z[j][l]   = r_z[j-1][l];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NST; j++) begin
            for (int l = 0; l < LANES; l++) begin
                logic [XW-1:0] x;
                logic [RW-1:0] r;
                logic [RW-1:0] t;
                logic [QW-1:0] q;
                x = s_x[j][l];
                r = s_r[j][l];
                q = s_q[j][l];
                for (int k = 0; k < SPS; k++) begin
                    if (SQRT) begin
                        r = {r[RW-3:0], x[XW-1:XW-2]};
                        x = x << 2;
                        t = RW'({q, 2'b01});
                    end else begin
                        r = {r[RW-2:0], x[XW-1]};
                        x = x << 1;
                        t = RW'(s_d[j][l]);
                    end
                    if (r >= t) begin
                        r = r - t;
                        q = {q[QW-2:0], 1'b1};
                    end else begin
                        q = {q[QW-2:0], 1'b0};
                    end
                end
                n_x[j][l] = x;
                n_r[j][l] = r;
                n_q[j][l] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) begin
                r_v[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < NST; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_ov <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= i_ctx;
            for (int j = 1; j < NST; j++) begin
                r_c[j] <= r_c[j-1];
            end
            r_oc <= r_c[NST-1];
            for (int j = 0; j < NST; j++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_x[j][l]   <= n_x[j][l];
                    r_r[j][l]   <= n_r[j][l];
                    r_q[j][l]   <= n_q[j][l];
                    r_d[j][l]   <= s_d[j][l];
                    r_neg[j][l] <= s_neg[j][l];
                    r_z[j][l]   <= s_z[j][l];
                end
            end
            for (int l = 0; l < LANES; l++) begin
                logic [MW-1:0] mag;
                if (CW'(r_q[NST-1][l]) > CW'(cfr_pkg::MAG_MAX)) begin
                    mag = cfr_pkg::MAG_MAX;
                end else begin
                    mag = MW'(r_q[NST-1][l]);
                end
                if (r_z[NST-1][l]) begin
                    r_o[l] <= '0;
                end else if (r_neg[NST-1][l]) begin
                    r_o[l] <= -cfr_pkg::t_fx'({1'b0, mag});
                end else begin
                    r_o[l] <= cfr_pkg::t_fx'({1'b0, mag});
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_ctx   = r_oc;
    assign o_p     = r_o;
endmodule

// ----- hw/rtl/conductor_fresnel_reflectance_top.sv -----
// Top level of the conductor Fresnel reflectance pipeline.
// Each item is one wavelength sample (incident index, complex conductor index, cosine of the
// incidence angle) and yields one unpolarised reflectance item in Q1.15. The block is a fully
// pipelined datapath: a new item may enter in every cycle, and each item passes through a
// chain of eight three-stage multiplier layers, two divider layers and two square-root layers,
// all resolving four quotient or root bits per stage, plus one register for each add layer
// and the output register. When the output item is not taken the whole pipeline holds, so
// i_in.ready falls only while a finished result waits; nothing is dropped or repeated.
module conductor_fresnel_reflectance_top #(
    parameter int FRAC_BITS = cfr_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cfr_in_if.sink          i_in,
    cfr_out_if.source       o_out
);
    typedef cfr_pkg::t_fx t_fx;

    // Values that ride alongside the arithmetic units until a later layer needs them.
    typedef struct packed {
        logic zero;
        t_fx  n1;
        t_fx  n2;
        t_fx  k2;
        t_fx  a_c;
        t_fx  b_r;
        t_fx  b_i;
        t_fx  s;
        t_fx  c2r;
        t_fx  c2i;
        t_fx  a_tr;
        t_fx  a_ti;
        t_fx  bt_r;
        t_fx  bt_i;
    } t_ctx;

    localparam int  CTXW  = $bits(t_ctx);
    localparam int  S12L  = FRAC_BITS >= 12 ? FRAC_BITS - 12 : 0;
    localparam int  S12R  = FRAC_BITS >= 12 ? 0 : 12 - FRAC_BITS;
    localparam int  S15L  = FRAC_BITS >= 15 ? FRAC_BITS - 15 : 0;
    localparam int  S15R  = FRAC_BITS >= 15 ? 0 : 15 - FRAC_BITS;
    localparam t_fx FX_ONE  = t_fx'(64'd1 << FRAC_BITS);
    localparam t_fx FX_HALF = t_fx'(64'd1 << (FRAC_BITS - 1));
    localparam logic [15:0] OUT_ONE = 16'd32768;

    // The whole pipeline advances together unless the output item is stalled.
    logic w_en;
    logic r_ov;
    logic [15:0] r_ores;

    assign w_en        = !r_ov || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_ov;
    assign o_out.reflectance = r_ores;

    // Input rescaling into the internal format; cosine values above one count as one.
    logic [cfr_pkg::FXW-1:0] w_n1, w_n2, w_k2, w_c;
    logic [15:0] w_craw;
    t_fx  w_a_m1 [8], w_b_m1 [8];
    t_ctx w_c_in;

    always_comb begin
        w_craw = (i_in.cos_incidence > OUT_ONE) ? OUT_ONE : i_in.cos_incidence;
        w_n1 = (cfr_pkg::FXW'(i_in.incident_index) << S12L) >> S12R;
        w_n2 = (cfr_pkg::FXW'(i_in.metal_index_real) << S12L) >> S12R;
        w_k2 = (cfr_pkg::FXW'(i_in.metal_extinction) << S12L) >> S12R;
        w_c  = (cfr_pkg::FXW'(w_craw) << S15L) >> S15R;
        w_a_m1 = '{t_fx'(w_n2), t_fx'(w_k2), t_fx'(w_n1), t_fx'(w_n1),
                   t_fx'(w_c), t_fx'(w_n1), t_fx'(w_n2), t_fx'(w_k2)};
        w_b_m1 = '{t_fx'(w_n2), t_fx'(w_k2), t_fx'(w_n2), t_fx'(w_k2),
                   t_fx'(w_c), t_fx'(w_c), t_fx'(w_c), t_fx'(w_c)};
        w_c_in    = '0;
        w_c_in.n1 = t_fx'(w_n1);
        w_c_in.n2 = t_fx'(w_n2);
        w_c_in.k2 = t_fx'(w_k2);
    end

    // Layer 1: squares of the index parts and of the cosine, the eta numerators and the
    // products of the cosine with both indices.
    logic v_m1;
    t_fx  p_m1 [8];
    t_ctx c_m1;
    cfr_mul #(.LANES(8), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_in.valid),
        .i_a(w_a_m1), .i_b(w_b_m1), .i_ctx(w_c_in),
        .o_valid(v_m1), .o_p(p_m1), .o_ctx(c_m1));

    logic r_v_a1;
    t_ctx r_c_a1;
    t_fx  r_a_d1 [2], r_b_d1 [2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a1 <= 1'b0;
        end else if (w_en) begin
            r_v_a1 <= v_m1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            t_fx  den;
            t_ctx ctx;
            den      = cfr_pkg::fx_add(p_m1[0], p_m1[1]);
            ctx      = c_m1;
            ctx.zero = den[cfr_pkg::FXW-1] || den == '0;
            ctx.s    = cfr_pkg::fx_sub(FX_ONE, p_m1[4]);
            ctx.a_c  = p_m1[5];
            ctx.b_r  = p_m1[6];
            ctx.b_i  = p_m1[7];
            r_c_a1 <= ctx;
            r_a_d1 <= '{p_m1[2], p_m1[3]};
            r_b_d1 <= '{den, den};
        end
    end

    // Layer 2: real and imaginary parts of eta.
    logic v_d1;
    t_fx  p_d1 [2];
    t_ctx c_d1;
    cfr_recur #(.SQRT(1'b0), .LANES(2), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_d1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a1),
        .i_a(r_a_d1), .i_b(r_b_d1), .i_ctx(r_c_a1),
        .o_valid(v_d1), .o_p(p_d1), .o_ctx(c_d1));

    logic r_v_a2;
    t_ctx r_c_a2;
    t_fx  r_a_m2 [3], r_b_m2 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a2 <= 1'b0;
        end else if (w_en) begin
            r_v_a2 <= v_d1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a2 <= c_d1;
            r_a_m2 <= '{p_d1[0], -p_d1[1], cfr_pkg::fx_add(p_d1[0], p_d1[0])};
            r_b_m2 <= '{p_d1[0], -p_d1[1], -p_d1[1]};
        end
    end

    // Layer 3: eta squared.
    logic v_m2;
    t_fx  p_m2 [3];
    t_ctx c_m2;
    cfr_mul #(.LANES(3), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a2),
        .i_a(r_a_m2), .i_b(r_b_m2), .i_ctx(r_c_a2),
        .o_valid(v_m2), .o_p(p_m2), .o_ctx(c_m2));

    logic r_v_a3;
    t_ctx r_c_a3;
    t_fx  r_a_m3 [2], r_b_m3 [2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a3 <= 1'b0;
        end else if (w_en) begin
            r_v_a3 <= v_m2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a3 <= c_m2;
            r_a_m3 <= '{cfr_pkg::fx_sub(p_m2[0], p_m2[1]), p_m2[2]};
            r_b_m3 <= '{c_m2.s, -c_m2.s};
        end
    end

    // Layer 4: eta squared times the squared sine.
    logic v_m3;
    t_fx  p_m3 [2];
    t_ctx c_m3;
    cfr_mul #(.LANES(2), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a3),
        .i_a(r_a_m3), .i_b(r_b_m3), .i_ctx(r_c_a3),
        .o_valid(v_m3), .o_p(p_m3), .o_ctx(c_m3));

    logic r_v_a4;
    t_ctx r_c_a4;
    t_fx  r_a_m4 [2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a4 <= 1'b0;
        end else if (w_en) begin
            r_v_a4 <= v_m3;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            t_fx  c2r;
            t_ctx ctx;
            c2r     = cfr_pkg::fx_sub(FX_ONE, p_m3[0]);
            ctx     = c_m3;
            ctx.c2r = c2r;
            ctx.c2i = p_m3[1];
            r_c_a4 <= ctx;
            r_a_m4 <= '{c2r, p_m3[1]};
        end
    end

    // Layer 5: squared magnitude of the transmitted cosine squared.
    logic v_m4;
    t_fx  p_m4 [2];
    t_ctx c_m4;
    cfr_mul #(.LANES(2), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a4),
        .i_a(r_a_m4), .i_b(r_a_m4), .i_ctx(r_c_a4),
        .o_valid(v_m4), .o_p(p_m4), .o_ctx(c_m4));

    logic r_v_a5;
    t_ctx r_c_a5;
    t_fx  r_a_s1 [1], w_zero1 [1];
    assign w_zero1 = '{t_fx'(0)};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a5 <= 1'b0;
        end else if (w_en) begin
            r_v_a5 <= v_m4;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a5 <= c_m4;
            r_a_s1 <= '{cfr_pkg::fx_add(p_m4[0], p_m4[1])};
        end
    end

    // Layer 6: modulus of the complex radicand.
    logic v_s1;
    t_fx  p_s1 [1];
    t_ctx c_s1;
    cfr_recur #(.SQRT(1'b1), .LANES(1), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_s1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a5),
        .i_a(r_a_s1), .i_b(w_zero1), .i_ctx(r_c_a5),
        .o_valid(v_s1), .o_p(p_s1), .o_ctx(c_s1));

    logic r_v_a6;
    t_ctx r_c_a6;
    t_fx  r_b_m5 [2], w_half2 [2];
    assign w_half2 = '{FX_HALF, FX_HALF};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a6 <= 1'b0;
        end else if (w_en) begin
            r_v_a6 <= v_s1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a6 <= c_s1;
            r_b_m5 <= '{cfr_pkg::fx_add(c_s1.c2r, p_s1[0]),
                        cfr_pkg::fx_sub(p_s1[0], c_s1.c2r)};
        end
    end

    // Layer 7: halving ahead of the principal complex square root.
    logic v_m5;
    t_fx  p_m5 [2];
    t_ctx c_m5;
    cfr_mul #(.LANES(2), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a6),
        .i_a(w_half2), .i_b(r_b_m5), .i_ctx(r_c_a6),
        .o_valid(v_m5), .o_p(p_m5), .o_ctx(c_m5));

    logic r_v_a7;
    t_ctx r_c_a7;
    t_fx  r_a_s2 [2], w_zero2 [2];
    assign w_zero2 = '{t_fx'(0), t_fx'(0)};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a7 <= 1'b0;
        end else if (w_en) begin
            r_v_a7 <= v_m5;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a7 <= c_m5;
            r_a_s2 <= p_m5;
        end
    end

    // Layer 8: real and imaginary parts of the transmitted cosine.
    logic v_s2;
    t_fx  p_s2 [2];
    t_ctx c_s2;
    cfr_recur #(.SQRT(1'b1), .LANES(2), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_s2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a7),
        .i_a(r_a_s2), .i_b(w_zero2), .i_ctx(r_c_a7),
        .o_valid(v_s2), .o_p(p_s2), .o_ctx(c_s2));

    logic r_v_a8;
    t_ctx r_c_a8;
    t_fx  r_a_m6 [6], r_b_m6 [6];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a8 <= 1'b0;
        end else if (w_en) begin
            r_v_a8 <= v_s2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            t_fx cti;
            // The imaginary part follows the sign of the radicand's imaginary part.
            cti = c_s2.c2i[cfr_pkg::FXW-1] ? -p_s2[1] : p_s2[1];
            r_c_a8 <= c_s2;
            r_a_m6 <= '{c_s2.n1, c_s2.n1, c_s2.n2, c_s2.k2, c_s2.k2, c_s2.n2};
            r_b_m6 <= '{p_s2[0], cti, p_s2[0], cti, p_s2[0], cti};
        end
    end

    // Layer 9: index products with the transmitted cosine.
    logic v_m6;
    t_fx  p_m6 [6];
    t_ctx c_m6;
    cfr_mul #(.LANES(6), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m6 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a8),
        .i_a(r_a_m6), .i_b(r_b_m6), .i_ctx(r_c_a8),
        .o_valid(v_m6), .o_p(p_m6), .o_ctx(c_m6));

    logic r_v_a9;
    t_ctx r_c_a9;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a9 <= 1'b0;
        end else if (w_en) begin
            r_v_a9 <= v_m6;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            t_ctx ctx;
            ctx      = c_m6;
            ctx.a_tr = p_m6[0];
            ctx.a_ti = p_m6[1];
            ctx.bt_r = cfr_pkg::fx_sub(p_m6[2], p_m6[3]);
            ctx.bt_i = cfr_pkg::fx_add(p_m6[4], p_m6[5]);
            r_c_a9 <= ctx;
        end
    end

    // Sums and differences feeding the s and p numerators and denominators.
    logic r_v_a10;
    t_ctx r_c_a10;
    t_fx  r_a_m7 [7];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a10 <= 1'b0;
        end else if (w_en) begin
            r_v_a10 <= r_v_a9;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a10 <= r_c_a9;
            r_a_m7  <= '{cfr_pkg::fx_sub(r_c_a9.a_c, r_c_a9.bt_r),
                         r_c_a9.bt_i,
                         cfr_pkg::fx_add(r_c_a9.a_c, r_c_a9.bt_r),
                         cfr_pkg::fx_sub(r_c_a9.a_tr, r_c_a9.b_r),
                         cfr_pkg::fx_sub(r_c_a9.a_ti, r_c_a9.b_i),
                         cfr_pkg::fx_add(r_c_a9.a_tr, r_c_a9.b_r),
                         cfr_pkg::fx_add(r_c_a9.a_ti, r_c_a9.b_i)};
        end
    end

    // Layer 10: squared magnitudes.
    logic v_m7;
    t_fx  p_m7 [7];
    t_ctx c_m7;
    cfr_mul #(.LANES(7), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m7 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a10),
        .i_a(r_a_m7), .i_b(r_a_m7), .i_ctx(r_c_a10),
        .o_valid(v_m7), .o_p(p_m7), .o_ctx(c_m7));

    logic r_v_a11;
    t_ctx r_c_a11;
    t_fx  r_a_d2 [2], r_b_d2 [2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a11 <= 1'b0;
        end else if (w_en) begin
            r_v_a11 <= v_m7;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a11 <= c_m7;
            r_a_d2  <= '{cfr_pkg::fx_add(p_m7[0], p_m7[1]), cfr_pkg::fx_add(p_m7[3], p_m7[4])};
            r_b_d2  <= '{cfr_pkg::fx_add(p_m7[2], p_m7[1]), cfr_pkg::fx_add(p_m7[5], p_m7[6])};
        end
    end

    // Layer 11: Rs and Rp; a denominator that is not positive gives zero.
    logic v_d2;
    t_fx  p_d2 [2];
    t_ctx c_d2;
    cfr_recur #(.SQRT(1'b0), .LANES(2), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_d2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a11),
        .i_a(r_a_d2), .i_b(r_b_d2), .i_ctx(r_c_a11),
        .o_valid(v_d2), .o_p(p_d2), .o_ctx(c_d2));

    logic r_v_a12;
    t_ctx r_c_a12;
    t_fx  r_a_m8 [1], w_half1 [1];
    assign w_half1 = '{FX_HALF};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a12 <= 1'b0;
        end else if (w_en) begin
            r_v_a12 <= v_d2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_a12 <= c_d2;
            r_a_m8  <= '{cfr_pkg::fx_add(p_d2[0], p_d2[1])};
        end
    end

    // Layer 12: mean of the two polarisations.
    logic v_m8;
    t_fx  p_m8 [1];
    t_ctx c_m8;
    cfr_mul #(.LANES(1), .FRAC_BITS(FRAC_BITS), .TW(CTXW)) u_m8 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v_a12),
        .i_a(r_a_m8), .i_b(w_half1), .i_ctx(r_c_a12),
        .o_valid(v_m8), .o_p(p_m8), .o_ctx(c_m8));

    // Output register: clamp to [0, 1], rescale to Q1.15, and force zero when the
    // conductor index vanished in the internal format.
    logic [15:0] w_res;
    always_comb begin
        t_fx r;
        logic [cfr_pkg::FXW-1:0] u;
        r = p_m8[0];
        if (r[cfr_pkg::FXW-1]) begin
            r = '0;
        end else if (r > FX_ONE) begin
            r = FX_ONE;
        end
        u = (cfr_pkg::FXW'(r) >> S15L) << S15R;
        if (c_m8.zero) begin
            w_res = '0;
        end else if (u > cfr_pkg::FXW'(OUT_ONE)) begin
            w_res = OUT_ONE;
        end else begin
            w_res = u[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= v_m8;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ores <= w_res;
        end
    end
endmodule

// ----- hw/rtl/cfr_check.sv -----
// Port-level assertions for the conductor Fresnel reflectance block, bound to the top level.
module cfr_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_reflectance
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result item shown after reset");

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while the pipeline is stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_reflectance <= 16'd32768)
        else $error("reflectance above one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_reflectance))
        else $error("stalled result item changed");
endmodule

bind conductor_fresnel_reflectance_top cfr_check u_cfr_check (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_reflectance(o_out.reflectance)
);
